[hdl/tgr_pkg.sv]
// shared types, constants and encodings of the touch gesture recognizer
package tgr_pkg;

    localparam int COORD_WIDTH = 11;
    localparam int RAW_WIDTH   = 13;
    localparam int TIME_WIDTH  = 32;
    localparam int DIST_WIDTH  = 12;
    localparam int HOLD_WIDTH  = 24;
    localparam int SLOP_WIDTH  = 8;
    localparam int CFG_IDX_W   = 3;
    localparam int CFG_DATA_W  = 24;
    localparam int MAX_EVENTS  = 3;

    localparam int IN_BITS     = 1 + 2 * RAW_WIDTH + TIME_WIDTH;
    localparam int IN_TDATA_W  = ((IN_BITS + 7) / 8) * 8;
    localparam int OUT_BITS    = 2 + 2 * COORD_WIDTH + 2 * DIST_WIDTH;
    localparam int OUT_TDATA_W = ((OUT_BITS + 7) / 8) * 8;

    // register indexes
    localparam logic [CFG_IDX_W-1:0] CFG_SCREEN_WIDTH   = 3'd0;
    localparam logic [CFG_IDX_W-1:0] CFG_SCREEN_HEIGHT  = 3'd1;
    localparam logic [CFG_IDX_W-1:0] CFG_TOOLBAR_HEIGHT = 3'd2;
    localparam logic [CFG_IDX_W-1:0] CFG_EDGE_SIZE      = 3'd3;
    localparam logic [CFG_IDX_W-1:0] CFG_SLOP_PIXELS    = 3'd4;
    localparam logic [CFG_IDX_W-1:0] CFG_HOLD_CLICK_US  = 3'd5;

    // register reset values
    localparam logic [10:0]           RST_SCREEN_WIDTH   = 11'd800;
    localparam logic [10:0]           RST_SCREEN_HEIGHT  = 11'd480;
    localparam logic [10:0]           RST_TOOLBAR_HEIGHT = 11'd30;
    localparam logic [10:0]           RST_EDGE_SIZE      = 11'd18;
    localparam logic [SLOP_WIDTH-1:0] RST_SLOP_PIXELS    = 8'd12;
    localparam logic [HOLD_WIDTH-1:0] RST_HOLD_CLICK_US  = 24'd700000;

    typedef enum logic [1:0] {
        EV_MOVE   = 2'd0,
        EV_DOWN   = 2'd1,
        EV_UP     = 2'd2,
        EV_SCROLL = 2'd3
    } event_kind_t;

    typedef enum logic [1:0] {
        AREA_PAGE = 2'd0,
        AREA_DRAG = 2'd1,
        AREA_TAP  = 2'd2
    } touch_kind_t;

    typedef struct packed {
        logic [10:0]           screen_width;
        logic [10:0]           screen_height;
        logic [10:0]           toolbar_height;
        logic [10:0]           edge_size;
        logic [SLOP_WIDTH-1:0] slop_pixels;
        logic [HOLD_WIDTH-1:0] hold_click_us;
    } cfg_t;

    typedef struct packed {
        event_kind_t                  kind;
        logic [COORD_WIDTH-1:0]       pos_x;
        logic [COORD_WIDTH-1:0]       pos_y;
        logic signed [DIST_WIDTH-1:0] dx;
        logic signed [DIST_WIDTH-1:0] dy;
    } event_t;

    typedef struct packed {
        logic [1:0]                   cnt;
        event_t [MAX_EVENTS-1:0]      ev;
    } evset_t;

endpackage

[hdl/tgr_cfg_regs.sv]
// configuration register file of the touch gesture recognizer
module tgr_cfg_regs import tgr_pkg::*; (
    input  logic                  aclk,
    input  logic                  aresetn,
    input  logic                  cfg_we,
    input  logic [CFG_IDX_W-1:0]  cfg_index,
    input  logic [CFG_DATA_W-1:0] cfg_wdata,
    output cfg_t                  cfg
);

    cfg_t cfg_reg;
    cfg_t cfg_next;

    always_comb begin
        cfg_next = cfg_reg;
        if (cfg_we) begin
            unique case (cfg_index)
                CFG_SCREEN_WIDTH:   cfg_next.screen_width   = cfg_wdata[10:0];
                CFG_SCREEN_HEIGHT:  cfg_next.screen_height  = cfg_wdata[10:0];
                CFG_TOOLBAR_HEIGHT: cfg_next.toolbar_height = cfg_wdata[10:0];
                CFG_EDGE_SIZE:      cfg_next.edge_size      = cfg_wdata[10:0];
                CFG_SLOP_PIXELS:    cfg_next.slop_pixels    = cfg_wdata[SLOP_WIDTH-1:0];
                CFG_HOLD_CLICK_US:  cfg_next.hold_click_us  = cfg_wdata[HOLD_WIDTH-1:0];
                default:            cfg_next = cfg_reg;
            endcase
        end
    end

    always_ff @(posedge aclk) begin
        if (!aresetn) begin
            cfg_reg.screen_width   <= RST_SCREEN_WIDTH;
            cfg_reg.screen_height  <= RST_SCREEN_HEIGHT;
            cfg_reg.toolbar_height <= RST_TOOLBAR_HEIGHT;
            cfg_reg.edge_size      <= RST_EDGE_SIZE;
            cfg_reg.slop_pixels    <= RST_SLOP_PIXELS;
            cfg_reg.hold_click_us  <= RST_HOLD_CLICK_US;
        end else begin
            cfg_reg <= cfg_next;
        end
    end

    assign cfg = cfg_reg;

endmodule

[hdl/tgr_core.sv]
// gesture state and the event decision for one touch sample
module tgr_core import tgr_pkg::*; (
    input  logic                         aclk,
    input  logic                         aresetn,
    input  cfg_t                         cfg,
    input  logic                         load,
    input  logic                         contact,
    input  logic signed [RAW_WIDTH-1:0]  raw_x,
    input  logic signed [RAW_WIDTH-1:0]  raw_y,
    input  logic [TIME_WIDTH-1:0]        time_us,
    output evset_t                       evs
);

    logic                   finger_down_reg, finger_down_next;
    touch_kind_t            touch_kind_reg, touch_kind_next;
    logic [COORD_WIDTH-1:0] start_x_reg, start_x_next;
    logic [COORD_WIDTH-1:0] start_y_reg, start_y_next;
    logic [COORD_WIDTH-1:0] last_x_reg, last_x_next;
    logic [COORD_WIDTH-1:0] last_y_reg, last_y_next;
    logic [TIME_WIDTH-1:0]  down_time_reg, down_time_next;
    logic                   is_scrolling_reg, is_scrolling_next;
    logic                   click_sent_reg, click_sent_next;

    logic [COORD_WIDTH-1:0]       x, y;
    touch_kind_t                  new_kind;
    logic signed [12:0]           edge_x_lim, edge_y_lim;
    logic signed [DIST_WIDTH-1:0] dx_last, dy_last, dx_start, dy_start;
    logic signed [DIST_WIDTH-1:0] sx, sy;
    logic                         past_slop, start_scroll, scrolling_now;
    logic [TIME_WIDTH-1:0]        elapsed;
    logic                         hold_done;

    // clamp a raw coordinate to [0, size-1], zero-sized axis gives zero
    function automatic logic [COORD_WIDTH-1:0] clamp_axis(
        input logic signed [RAW_WIDTH-1:0] v,
        input logic [10:0]                 size
    );
        logic [COORD_WIDTH-1:0] top;
        top = (size == '0) ? '0 : COORD_WIDTH'(size - 11'd1);
        if (v < 0)
            return '0;
        else if ($unsigned(v[RAW_WIDTH-2:0]) > (RAW_WIDTH-1)'(top))
            return top;
        else
            return COORD_WIDTH'(v[RAW_WIDTH-2:0]);
    endfunction

    function automatic logic signed [DIST_WIDTH-1:0] diff(
        input logic [COORD_WIDTH-1:0] a,
        input logic [COORD_WIDTH-1:0] b
    );
        return $signed({1'b0, a}) - $signed({1'b0, b});
    endfunction

    function automatic logic [DIST_WIDTH-1:0] mag(input logic signed [DIST_WIDTH-1:0] d);
        return (d < 0) ? $unsigned(-d) : $unsigned(d);
    endfunction

    function automatic event_t mk_event(
        input event_kind_t            k,
        input logic [COORD_WIDTH-1:0] px,
        input logic [COORD_WIDTH-1:0] py
    );
        event_t e;
        e       = '0;
        e.kind  = k;
        e.pos_x = px;
        e.pos_y = py;
        return e;
    endfunction

    always_comb begin
        x = contact ? clamp_axis(raw_x, cfg.screen_width)  : '0;
        y = contact ? clamp_axis(raw_y, cfg.screen_height) : '0;

        // strip limits may go negative, then the whole lower area is strip
        edge_x_lim = $signed({2'b00, cfg.screen_width})  - $signed({2'b00, cfg.edge_size});
        edge_y_lim = $signed({2'b00, cfg.screen_height}) - $signed({2'b00, cfg.edge_size});
        priority if (y < cfg.toolbar_height)
            new_kind = AREA_TAP;
        else if ($signed({2'b00, x}) >= edge_x_lim || $signed({2'b00, y}) >= edge_y_lim)
            new_kind = AREA_DRAG;
        else
            new_kind = AREA_PAGE;

        dx_last  = diff(x, last_x_reg);
        dy_last  = diff(y, last_y_reg);
        dx_start = diff(x, start_x_reg);
        dy_start = diff(y, start_y_reg);
        past_slop = (mag(dx_start) > {4'b0, cfg.slop_pixels}) ||
                    (mag(dy_start) > {4'b0, cfg.slop_pixels});
        start_scroll  = (touch_kind_reg == AREA_PAGE) && !is_scrolling_reg && past_slop;
        scrolling_now = is_scrolling_reg || start_scroll;
        sx = start_scroll ? -dx_start : -dx_last;
        sy = start_scroll ? -dy_start : -dy_last;

        elapsed   = time_us - down_time_reg;
        hold_done = elapsed >= {{(TIME_WIDTH-HOLD_WIDTH){1'b0}}, cfg.hold_click_us};
    end

    always_comb begin
        evs               = '0;
        finger_down_next  = finger_down_reg;
        touch_kind_next   = touch_kind_reg;
        start_x_next      = start_x_reg;
        start_y_next      = start_y_reg;
        last_x_next       = last_x_reg;
        last_y_next       = last_y_reg;
        down_time_next    = down_time_reg;
        is_scrolling_next = is_scrolling_reg;
        click_sent_next   = click_sent_reg;

        priority if (contact && !finger_down_reg) begin
            // touch down
            finger_down_next  = 1'b1;
            touch_kind_next   = new_kind;
            start_x_next      = x;
            start_y_next      = y;
            last_x_next       = x;
            last_y_next       = y;
            down_time_next    = time_us;
            is_scrolling_next = 1'b0;
            click_sent_next   = 1'b0;
            evs.ev[0]         = mk_event(EV_MOVE, x, y);
            if (new_kind == AREA_DRAG) begin
                evs.ev[1] = mk_event(EV_DOWN, '0, '0);
                evs.cnt   = 2'd2;
            end else begin
                evs.cnt   = 2'd1;
            end
        end else if (contact) begin
            last_x_next = x;
            last_y_next = y;
            if (touch_kind_reg == AREA_DRAG) begin
                if (dx_last != 0 || dy_last != 0) begin
                    evs.ev[0] = mk_event(EV_MOVE, x, y);
                    evs.cnt   = 2'd1;
                end
            end else if (!click_sent_reg) begin
                if (scrolling_now) begin
                    is_scrolling_next = 1'b1;
                    if (sx != 0 || sy != 0) begin
                        evs.ev[0]      = mk_event(EV_SCROLL, '0, '0);
                        evs.ev[0].dx   = sx;
                        evs.ev[0].dy   = sy;
                        evs.cnt        = 2'd1;
                    end
                end else if (hold_done) begin
                    // long press click at the down point
                    evs.ev[0]       = mk_event(EV_MOVE, start_x_reg, start_y_reg);
                    evs.ev[1]       = mk_event(EV_DOWN, '0, '0);
                    evs.ev[2]       = mk_event(EV_UP, '0, '0);
                    evs.cnt         = 2'd3;
                    click_sent_next = 1'b1;
                end
            end
        end else if (finger_down_reg) begin
            // release
            finger_down_next = 1'b0;
            if (touch_kind_reg == AREA_DRAG) begin
                evs.ev[0] = mk_event(EV_UP, '0, '0);
                evs.cnt   = 2'd1;
            end else if (!is_scrolling_reg && !click_sent_reg) begin
                evs.ev[0]       = mk_event(EV_MOVE, start_x_reg, start_y_reg);
                evs.ev[1]       = mk_event(EV_DOWN, '0, '0);
                evs.ev[2]       = mk_event(EV_UP, '0, '0);
                evs.cnt         = 2'd3;
                click_sent_next = 1'b1;
            end
        end else begin
            evs.cnt = 2'd0;
        end
    end

    always_ff @(posedge aclk) begin
        if (!aresetn) begin
            finger_down_reg  <= 1'b0;
            touch_kind_reg   <= AREA_PAGE;
            start_x_reg      <= '0;
            start_y_reg      <= '0;
            last_x_reg       <= '0;
            last_y_reg       <= '0;
            down_time_reg    <= '0;
            is_scrolling_reg <= 1'b0;
            click_sent_reg   <= 1'b0;
        end else if (load) begin
            finger_down_reg  <= finger_down_next;
            touch_kind_reg   <= touch_kind_next;
            start_x_reg      <= start_x_next;
            start_y_reg      <= start_y_next;
            last_x_reg       <= last_x_next;
            last_y_reg       <= last_y_next;
            down_time_reg    <= down_time_next;
            is_scrolling_reg <= is_scrolling_next;
            click_sent_reg   <= click_sent_next;
        end
    end

endmodule

[hdl/tgr_evq.sv]
// result register holding the events of one sample, sent one beat at a time
module tgr_evq import tgr_pkg::*; (
    input  logic   aclk,
    input  logic   aresetn,
    input  logic   load,
    input  evset_t evs,
    output logic   free,
    output logic   m_valid,
    input  logic   m_ready,
    output event_t m_event,
    output logic   m_last
);

    event_t [MAX_EVENTS-1:0] ev_reg;
    logic [1:0]              cnt_reg, cnt_next;
    logic [1:0]              idx_reg, idx_next;
    logic                    pop;

    assign m_valid = idx_reg < cnt_reg;
    assign m_last  = (idx_reg == cnt_reg - 2'd1);
    assign m_event = ev_reg[idx_reg];
    assign pop     = m_valid && m_ready;
    assign free    = !m_valid || (m_ready && m_last);

    always_comb begin
        cnt_next = cnt_reg;
        idx_next = idx_reg;
        priority if (load) begin
            cnt_next = evs.cnt;
            idx_next = '0;
        end else if (pop && m_last) begin
            cnt_next = '0;
            idx_next = '0;
        end else if (pop) begin
            idx_next = idx_reg + 2'd1;
        end
    end

    always_ff @(posedge aclk) begin
        if (!aresetn) begin
            cnt_reg <= '0;
            idx_reg <= '0;
        end else begin
            cnt_reg <= cnt_next;
            idx_reg <= idx_next;
        end
    end

    always_ff @(posedge aclk) begin
        if (load) begin
            ev_reg <= evs.ev;
        end
    end

endmodule

[hdl/touch_gesture_recognizer.sv]
// top level of the touch gesture recognizer
// Takes one touch-panel sample per input beat (contact flag, raw x/y, wrapping
// microsecond timestamp), clamps the point to the screen and turns the touch
// into pointer events: absolute move, button down, button up and scroll.
// A sample is held in an input register, decided in one pass of logic against
// the gesture state, and its zero to three events land together in a result
// register that sends them one beat each, the final one with m_tlast set.
// A new sample is taken while the previous sample's last event is being
// handed off, so the block runs at one sample per cycle when a sample makes
// at most one event and the output never stalls; a sample with more events
// holds the result register until its last event is taken. Events leave the
// result register after the sample passes the input register. Samples that
// make no event are absorbed with no output beat. The user must see that
// registers are written on the cfg port only while idle; the block does not
// enforce it. Indexes are 0 screen_width, 1 screen_height, 2 toolbar_height,
// 3 edge_size, 4 slop_pixels, 5 hold_click_us; writes elsewhere are ignored.
module touch_gesture_recognizer import tgr_pkg::*; (
    input  logic                   aclk,
    input  logic                   aresetn,
    // configuration write port
    input  logic                   cfg_we,
    input  logic [CFG_IDX_W-1:0]   cfg_index,
    input  logic [CFG_DATA_W-1:0]  cfg_wdata,
    // sample input
    input  logic                   s_tvalid,
    output logic                   s_tready,
    // contact[0], raw_x[13:1], raw_y[26:14], time_us[58:27], zero fill above
    input  logic [IN_TDATA_W-1:0]  s_tdata,
    // event output
    output logic                   m_tvalid,
    input  logic                   m_tready,
    // event_kind[1:0], pos_x[12:2], pos_y[23:13], scroll_dx[35:24], scroll_dy[47:36]
    output logic [OUT_TDATA_W-1:0] m_tdata,
    output logic                   m_tlast
);

    cfg_t   cfg;
    evset_t evs;
    event_t m_event;
    logic   q_free;
    logic   load;

    // input register
    logic                        in_valid_reg, in_valid_next;
    logic                        contact_reg;
    logic signed [RAW_WIDTH-1:0] raw_x_reg, raw_y_reg;
    logic [TIME_WIDTH-1:0]       time_us_reg;
    logic                        s_beat;

    tgr_cfg_regs u_cfg (
        .aclk      (aclk),
        .aresetn   (aresetn),
        .cfg_we    (cfg_we),
        .cfg_index (cfg_index),
        .cfg_wdata (cfg_wdata),
        .cfg       (cfg)
    );

    // sample moves into the gesture logic once the result register frees up
    assign load     = in_valid_reg && q_free;
    assign s_tready = !in_valid_reg || load;
    assign s_beat   = s_tvalid && s_tready;

    always_comb begin
        in_valid_next = in_valid_reg;
        priority if (s_beat)
            in_valid_next = 1'b1;
        else if (load)
            in_valid_next = 1'b0;
        else
            in_valid_next = in_valid_reg;
    end

    always_ff @(posedge aclk) begin
        if (!aresetn) begin
            in_valid_reg <= 1'b0;
        end else begin
            in_valid_reg <= in_valid_next;
        end
    end

    always_ff @(posedge aclk) begin
        if (s_beat) begin
            contact_reg <= s_tdata[0];
            raw_x_reg   <= $signed(s_tdata[RAW_WIDTH:1]);
            raw_y_reg   <= $signed(s_tdata[2*RAW_WIDTH:RAW_WIDTH+1]);
            time_us_reg <= s_tdata[2*RAW_WIDTH+TIME_WIDTH:2*RAW_WIDTH+1];
        end
    end

    tgr_core u_core (
        .aclk    (aclk),
        .aresetn (aresetn),
        .cfg     (cfg),
        .load    (load),
        .contact (contact_reg),
        .raw_x   (raw_x_reg),
        .raw_y   (raw_y_reg),
        .time_us (time_us_reg),
        .evs     (evs)
    );

    tgr_evq u_evq (
        .aclk    (aclk),
        .aresetn (aresetn),
        .load    (load),
        .evs     (evs),
        .free    (q_free),
        .m_valid (m_tvalid),
        .m_ready (m_tready),
        .m_event (m_event),
        .m_last  (m_tlast)
    );

    // pack event fields, kind in the lowest bits
    assign m_tdata = {{(OUT_TDATA_W-OUT_BITS){1'b0}},
                      m_event.dy, m_event.dx, m_event.pos_y, m_event.pos_x, m_event.kind};

    // a scroll is always the only event of its sample
    a_scroll_alone: assert property (@(posedge aclk) disable iff (!aresetn)
        m_tvalid && m_event.kind == EV_SCROLL |-> m_tlast)
        else $error("scroll event not alone in its sample");

    // only moves carry a position, only scrolls carry a distance; the check covers the position
    a_payload_zero: assert property (@(posedge aclk) disable iff (!aresetn)
        m_tvalid && m_event.kind != EV_MOVE |-> m_event.pos_x == '0 && m_event.pos_y == '0)
        else $error("non-move event with nonzero position");

    // a new sample never overwrites events still waiting to go out
    a_no_overwrite: assert property (@(posedge aclk) disable iff (!aresetn)
        load |-> !m_tvalid || (m_tready && m_tlast))
        else $error("result register overwritten");

    // a held sample that cannot move on blocks the input
    a_backpressure: assert property (@(posedge aclk) disable iff (!aresetn)
        in_valid_reg && !q_free |-> !s_tready)
        else $error("input accepted while sample is stuck");

endmodule
